### rtl/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
package bhpq_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CNT_OUT_W  = 11;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned M_TDATA_W  = 48;
  localparam int unsigned M_PAD_W    = M_TDATA_W - DATA_W - CNT_OUT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_RD,
    S_UP_CMP,
    S_RM_WAIT,
    S_RP_WAIT,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_TOP,
    RD_TOP_LAST,
    RD_CHILDREN
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_VAL,
    WR_PARENT,
    WR_CHILD
  } wr_sel_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_NEWLAST,
    POS_ROOT,
    POS_PARENT,
    POS_CHILD
  } pos_sel_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_ZERO,
    RES_TOP,
    RES_VAL
  } res_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     load_in;
    logic     val_from_last;
    cnt_sel_e cnt_sel;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    pos_sel_e pos_sel;
    res_sel_e res_sel;
    logic     st_load;
    stat_e    st_code;
    logic     load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic full;
    logic cnt_one;
    logic at_root;
    logic up_go;
    logic rp_go;
    logic dn_more;
    logic dn_go;
  } dp_stat_t;

  // true when a must sit strictly above b
  function automatic logic comes_first(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b,
                                       input logic max_first);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return max_first ? gt : lt;
  endfunction

endpackage

### rtl/bhpq_ctrl.sv
// Sequencing state machine for the heap priority queue.
module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_INSERT:  state_d = stat_i.full  ? S_FINISH : S_UP_RD;
          CMD_REMOVE:  state_d = stat_i.empty ? S_FINISH : S_RM_WAIT;
          CMD_REPLACE: state_d = stat_i.empty ? S_FINISH : S_RP_WAIT;
          default:     state_d = S_FINISH;
        endcase
      end
      S_UP_RD:   state_d = stat_i.at_root ? S_FINISH : S_UP_CMP;
      S_UP_CMP:  state_d = stat_i.up_go ? S_UP_RD : S_FINISH;
      S_RM_WAIT: state_d = stat_i.cnt_one ? S_FINISH : S_DN_RD;
      S_RP_WAIT: state_d = stat_i.rp_go ? S_DN_RD : S_FINISH;
      S_DN_RD:   state_d = stat_i.dn_more ? S_DN_CMP : S_FINISH;
      S_DN_CMP:  state_d = stat_i.dn_go ? S_DN_RD : S_FINISH;
      S_FINISH: begin
        if (!out_valid_q || m_ready_i) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o               = '0;
    cmd_o.cnt_sel       = CNT_HOLD;
    cmd_o.rd_sel        = RD_NONE;
    cmd_o.wr_sel        = WR_NONE;
    cmd_o.pos_sel       = POS_HOLD;
    cmd_o.res_sel       = RES_HOLD;
    cmd_o.st_code       = STAT_OK;
    out_valid_d         = out_valid_q && !m_ready_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_in = s_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.st_load = 1'b1;
        cmd_o.res_sel = RES_ZERO;
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.full) begin
              cmd_o.st_code = STAT_FULL;
            end else begin
              cmd_o.cnt_sel = CNT_INC;
              cmd_o.pos_sel = POS_NEWLAST;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.st_code = STAT_EMPTY;
            end else begin
              cmd_o.rd_sel = RD_TOP_LAST;
            end
          end
          CMD_REPLACE: begin
            if (stat_i.empty) begin
              cmd_o.res_sel = RES_VAL;
            end else begin
              cmd_o.rd_sel = RD_TOP;
            end
          end
          default: cmd_o.cnt_sel = CNT_CLEAR;
        endcase
      end
      S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.wr_sel = WR_VAL;
        end else begin
          cmd_o.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_go) begin
          cmd_o.wr_sel  = WR_PARENT;
          cmd_o.pos_sel = POS_PARENT;
        end else begin
          cmd_o.wr_sel = WR_VAL;
        end
      end
      S_RM_WAIT: begin
        cmd_o.res_sel       = RES_TOP;
        cmd_o.val_from_last = 1'b1;
        cmd_o.cnt_sel       = CNT_DEC;
        cmd_o.pos_sel       = POS_ROOT;
      end
      S_RP_WAIT: begin
        if (stat_i.rp_go) begin
          cmd_o.res_sel = RES_TOP;
          cmd_o.pos_sel = POS_ROOT;
        end else begin
          cmd_o.res_sel = RES_VAL;
        end
      end
      S_DN_RD: begin
        if (stat_i.dn_more) begin
          cmd_o.rd_sel = RD_CHILDREN;
        end else begin
          cmd_o.wr_sel = WR_VAL;
        end
      end
      S_DN_CMP: begin
        if (stat_i.dn_go) begin
          cmd_o.wr_sel  = WR_CHILD;
          cmd_o.pos_sel = POS_CHILD;
        end else begin
          cmd_o.wr_sel = WR_VAL;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_o |=> state_q == S_DISPATCH)
    else $error("accepted word not dispatched");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_ready_i))
    else $error("output word overwritten while stalled");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("output valid without finished command");

endmodule

### rtl/bhpq_dp.sv
// Heap store, position and count registers, comparators and output word.
module bhpq_dp
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic [CMD_W-1:0]      in_cmd_i,
  input  logic [DATA_W-1:0]     in_val_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  output logic [M_TDATA_W-1:0]  out_data_o,
  output logic [STAT_W-1:0]     out_user_o
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [PW-1:0] CapP = PW'(CAPACITY);
  localparam logic [PW-1:0] OneP = PW'(1);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic              order_q;
  logic [PW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  cmd_e              cmd_q, cmd_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [STAT_W-1:0]    out_user_q;

  logic [PW-1:0]     child_l, child_sel, parent;
  logic              right_sel;
  logic [DATA_W-1:0] child_val;
  logic              re_a, re_b, we;
  logic [PW-1:0]     ra_a, ra_b;
  logic [DATA_W-1:0] wd;

  function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
    logic [PW-1:0] z;
    z = p - OneP;
    return AW'(z);
  endfunction

  assign parent    = pos_q >> 1;
  assign child_l   = PW'({pos_q, 1'b0});
  assign right_sel = (child_l < cnt_q) && comes_first(rd_b_q, rd_a_q, order_q);
  assign child_val = right_sel ? rd_b_q : rd_a_q;
  assign child_sel = right_sel ? (child_l + OneP) : child_l;

  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    ra_a = OneP;
    ra_b = OneP;
    case (cmd_i.rd_sel)
      RD_PARENT: begin
        re_a = 1'b1;
        ra_a = parent;
      end
      RD_TOP: re_a = 1'b1;
      RD_TOP_LAST: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra_b = cnt_q;
      end
      RD_CHILDREN: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra_a = child_l;
        ra_b = (child_l < cnt_q) ? (child_l + OneP) : child_l;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wd = val_q;
    case (cmd_i.wr_sel)
      WR_VAL:    wd = val_q;
      WR_PARENT: wd = rd_a_q;
      WR_CHILD:  wd = child_val;
      default:   we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[to_addr(pos_q)] <= wd;
    if (re_a) rd_a_q <= mem[to_addr(ra_a)];
    if (re_b) rd_b_q <= mem[to_addr(ra_b)];
  end

  always_comb begin
    cnt_d = cnt_q;
    case (cmd_i.cnt_sel)
      CNT_CLEAR: cnt_d = '0;
      CNT_INC:   cnt_d = cnt_q + OneP;
      CNT_DEC:   cnt_d = cnt_q - OneP;
      default:   cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    case (cmd_i.pos_sel)
      POS_NEWLAST: pos_d = cnt_q + OneP;
      POS_ROOT:    pos_d = OneP;
      POS_PARENT:  pos_d = parent;
      POS_CHILD:   pos_d = child_sel;
      default:     pos_d = pos_q;
    endcase
  end

  always_comb begin
    res_d = res_q;
    case (cmd_i.res_sel)
      RES_ZERO: res_d = '0;
      RES_TOP:  res_d = rd_a_q;
      RES_VAL:  res_d = val_q;
      default:  res_d = res_q;
    endcase
  end

  assign val_d = cmd_i.load_in ? in_val_i :
                 (cmd_i.val_from_last ? rd_b_q : val_q);
  assign cmd_d = cmd_i.load_in ? cmd_e'(in_cmd_i) : cmd_q;
  assign st_d  = cmd_i.st_load ? cmd_i.st_code : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) order_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
    st_q  <= st_d;
    if (cmd_i.load_out) begin
      out_data_q <= {{M_PAD_W{1'b0}}, CNT_OUT_W'(cnt_q), res_q};
      out_user_q <= st_q;
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

  assign stat_o.cmd     = cmd_q;
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.full    = (cnt_q >= CapP);
  assign stat_o.cnt_one = (cnt_q == OneP);
  assign stat_o.at_root = (pos_q == OneP);
  assign stat_o.up_go   = comes_first(val_q, rd_a_q, order_q);
  assign stat_o.rp_go   = comes_first(rd_a_q, val_q, order_q);
  assign stat_o.dn_more = (pos_q <= (cnt_q >> 1));
  assign stat_o.dn_go   = comes_first(child_val, val_q, order_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapP)
    else $error("element count beyond capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (pos_q >= OneP && pos_q <= cnt_q))
    else $error("heap write outside held elements");

endmodule

### rtl/binary_heap_priority_queue.sv
// Binary heap priority queue, top level.
// Command flow: accept, dispatch, then a sift (insert climbs towards the root, remove and
// replace descend from the root), then finish, which loads the output word; clear, refused
// commands and replace on an empty heap go straight from dispatch to finish.
// Throughput: one command at a time, next word taken the cycle after the output word is
// loaded; a stalled output word holds the next command back.
// Reset (async, active low) empties the heap and selects min-first; store not cleared.
module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,     // order_max_first
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,    // value
  input  logic [CMD_W-1:0]     s_axis_tuser,    // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,    // result_value, count_after, zero pad
  output logic [STAT_W-1:0]    m_axis_tuser     // status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bhpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_val_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

### verif/binary_heap_priority_queue_test.sv
// Self-checking testbench for the heap priority queue: directed, random, fill and stall tests.
module binary_heap_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bhpq_pkg::*;

  localparam int unsigned HEAP_CAP    = 1024;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0]    value;
    stat_e                status;
    logic [CNT_OUT_W-1:0] count;
  } heap_reply_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_wdata_i   = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;
  logic [CMD_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;

  heap_reply_t       expected_replies[$];
  heap_reply_t       oldest_reply;
  logic [DATA_W-1:0] shadow_heap [1:HEAP_CAP];
  int unsigned       heap_size     = 0;
  bit                order_max     = 1'b0;
  int unsigned       fail_count    = 0;
  int unsigned       idle_pct      = 25;
  int unsigned       rx_hold_left  = 0;
  int unsigned       rx_stall_left = 0;
  int unsigned       quiet_cycles  = 0;

  binary_heap_priority_queue #(
    .CAPACITY(HEAP_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // a strictly outranks b in the current order
  function automatic bit ranks_above(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    if (order_max) return $signed(a) > $signed(b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void bubble_up(input int unsigned slot);
    logic [DATA_W-1:0] held;
    held = shadow_heap[slot];
    while (slot > 1 && ranks_above(held, shadow_heap[slot/2])) begin
      shadow_heap[slot] = shadow_heap[slot/2];
      slot = slot / 2;
    end
    shadow_heap[slot] = held;
  endfunction

  function automatic void push_down(input int unsigned slot);
    logic [DATA_W-1:0] held;
    int unsigned       child;
    held = shadow_heap[slot];
    while (slot <= heap_size / 2) begin
      child = slot * 2;
      if (child < heap_size && ranks_above(shadow_heap[child+1], shadow_heap[child])) child++;
      if (!ranks_above(shadow_heap[child], held)) break;
      shadow_heap[slot] = shadow_heap[child];
      slot = child;
    end
    shadow_heap[slot] = held;
  endfunction

  function automatic heap_reply_t apply_command(input cmd_e op, input logic [DATA_W-1:0] v);
    heap_reply_t r;
    r.value  = '0;
    r.status = STAT_OK;
    case (op)
      CMD_INSERT: begin
        if (heap_size >= HEAP_CAP) begin
          r.status = STAT_FULL;
        end else begin
          heap_size++;
          shadow_heap[heap_size] = v;
          bubble_up(heap_size);
        end
      end
      CMD_REMOVE: begin
        if (heap_size == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = shadow_heap[1];
          shadow_heap[1] = shadow_heap[heap_size];
          heap_size--;
          if (heap_size > 0) push_down(1);
        end
      end
      CMD_REPLACE: begin
        if (heap_size > 0 && ranks_above(shadow_heap[1], v)) begin
          r.value = shadow_heap[1];
          shadow_heap[1] = v;
          push_down(1);
        end else begin
          r.value = v;
        end
      end
      default: heap_size = 0;
    endcase
    r.count = CNT_OUT_W'(heap_size);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return DATA_W'($urandom_range(0, 10)) - 32'd5;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e pick_command(input int unsigned insert_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 3) return CMD_CLEAR;
    if (p < 3 + insert_pct) return CMD_INSERT;
    return p[0] ? CMD_REMOVE : CMD_REPLACE;
  endfunction

  task automatic send_word(input cmd_e op, input logic [DATA_W-1:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_replies.push_back(apply_command(op, v));
    @(negedge clk_i);
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_replies.size() != 0);
    @(negedge clk_i);
  endtask

  task automatic write_order(input bit max_first);
    drain_results;
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= max_first;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    order_max = max_first;
  endtask

  task automatic mixed_commands(input int unsigned n, input int unsigned insert_pct);
    repeat (n) send_word(pick_command(insert_pct), pick_value());
  endtask

  task automatic test_directed;
    write_order(1'b0);
    send_word(CMD_REMOVE,  32'h1234_5678);
    send_word(CMD_REPLACE, 32'd5);
    send_word(CMD_INSERT,  32'h7fff_ffff);
    send_word(CMD_INSERT,  32'h8000_0000);
    send_word(CMD_INSERT,  32'h0000_0000);
    send_word(CMD_INSERT,  32'hffff_ffff);
    send_word(CMD_INSERT,  32'h0000_0001);
    send_word(CMD_INSERT,  32'h0000_0000);
    send_word(CMD_REPLACE, 32'h8000_0000);  // tie with top
    send_word(CMD_REPLACE, 32'h7fff_ffff);
    send_word(CMD_REPLACE, 32'h8000_0000);
    repeat (4) send_word(CMD_REMOVE, 32'hffff_ffff);
    send_word(CMD_CLEAR,   32'hdead_beef);
    send_word(CMD_REMOVE,  32'h0000_0000);
    send_word(CMD_REPLACE, 32'h8000_0000);
    send_word(CMD_INSERT,  32'h5555_aaaa);
    send_word(CMD_CLEAR,   32'h0000_0000);
  endtask

  task automatic test_random_min_first;
    mixed_commands(40, 40);
  endtask

  // order changed while entries are held, no reordering expected
  task automatic test_order_flip;
    repeat (6) send_word(CMD_INSERT, pick_value());
    write_order(1'b1);
    mixed_commands(30, 35);
  endtask

  task automatic test_back_pressure;
    @(posedge clk_i);
    rx_hold_left = LONG_HOLD;
    @(negedge clk_i);
    mixed_commands(20, 50);
    drain_results;
  endtask

  task automatic test_fill_to_capacity;
    write_order(1'b1);
    idle_pct = 0;
    while (heap_size < HEAP_CAP) send_word(CMD_INSERT, pick_value());
    idle_pct = 25;
    send_word(CMD_INSERT,  32'h7fff_ffff);
    send_word(CMD_INSERT,  32'h8000_0000);
    send_word(CMD_INSERT,  $urandom());
    send_word(CMD_REPLACE, pick_value());
    write_order(1'b0);
    mixed_commands(20, 15);
  endtask

  task automatic test_calm_tail;
    idle_pct = 0;
    mixed_commands(20, 40);
    send_word(CMD_CLEAR,  $urandom());
    send_word(CMD_REMOVE, $urandom());
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word value=%h status=%0d count=%0d", $time,
                 m_axis_tdata[DATA_W-1:0], m_axis_tuser, m_axis_tdata[DATA_W +: CNT_OUT_W]);
      end else begin
        oldest_reply = expected_replies.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== oldest_reply.value ||
            m_axis_tuser !== oldest_reply.status ||
            m_axis_tdata[DATA_W +: CNT_OUT_W] !== oldest_reply.count) begin
          fail_count++;
          $display("%0t: exp value=%h status=%0d count=%0d, got value=%h status=%0d count=%0d",
                   $time, oldest_reply.value, oldest_reply.status, oldest_reply.count,
                   m_axis_tdata[DATA_W-1:0], m_axis_tuser, m_axis_tdata[DATA_W +: CNT_OUT_W]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed;
    test_random_min_first;
    test_order_flip;
    test_back_pressure;
    test_fill_to_capacity;
    test_calm_tail;
    drain_results;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### binary_heap_priority_queue.f
rtl/bhpq_pkg.sv
rtl/bhpq_ctrl.sv
rtl/bhpq_dp.sv
rtl/binary_heap_priority_queue.sv
verif/binary_heap_priority_queue_test.sv
